// ----- hdl/oate_pkg.sv -----
// Shared types, codes and widths for the ordered array table engine.
`default_nettype none

package oate_pkg;

  localparam int unsigned DepthDefault = 32;
  localparam int unsigned PosW         = 6;
  localparam int unsigned IdxOutW      = 5;
  localparam int unsigned DataW        = 32;

  // request command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_SEARCH = 3'd2;
  localparam logic [2:0] CMD_SORT   = 3'd3;
  localparam logic [2:0] CMD_DUMP   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADPOS   = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [2:0]              command;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] operand_value;
  } oate_req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [IdxOutW-1:0]      found_index;
    logic signed [DataW-1:0] element;
    logic                    last;
  } oate_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CHK,
    S_DEL_WR,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_SORT_PASS,
    S_SORT_LD,
    S_SORT_CHK,
    S_SORT_WR,
    S_DUMP_RD,
    S_DUMP_OUT
  } oate_state_e;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_ZERO, PTR_ONE, PTR_COUNT, PTR_POS, PTR_INC, PTR_DEC
  } oate_ptr_op_e;

  typedef enum logic [1:0] {RA_PTR, RA_PTR_M1, RA_PTR_P1, RA_ZERO} oate_rd_sel_e;
  typedef enum logic {WA_PTR, WA_PTR_M1} oate_wa_sel_e;
  typedef enum logic [1:0] {WD_RDATA, WD_OPERAND, WD_MIN, WD_CARRY} oate_wd_sel_e;
  typedef enum logic [1:0] {CARRY_HOLD, CARRY_RDATA, CARRY_MAX} oate_carry_op_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} oate_cnt_op_e;
  typedef enum logic [1:0] {PASS_HOLD, PASS_LOAD, PASS_DEC} oate_pass_op_e;
  typedef enum logic [1:0] {RES_PLAIN, RES_INDEX, RES_DUMP} oate_res_kind_e;

  // controller to datapath
  typedef struct packed {
    logic           req_load;
    oate_ptr_op_e   ptr_op;
    logic           rd_en;
    oate_rd_sel_e   rd_sel;
    logic           wr_en;
    oate_wa_sel_e   wa_sel;
    oate_wd_sel_e   wd_sel;
    oate_carry_op_e carry_op;
    oate_cnt_op_e   cnt_op;
    oate_pass_op_e  pass_op;
    logic           res_en;
    logic [2:0]     res_status;
    oate_res_kind_e res_kind;
  } oate_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] command;
    logic       pos_gt_count;
    logic       pos_lt_count;
    logic       count_full;
    logic       count_zero;
    logic       count_lt2;
    logic       ptr_gt_pos;
    logic       ptr_lt_count;
    logic       ptr_next_lt_count;
    logic       match;
    logic       pass_last;
  } oate_sts_t;

endpackage

`default_nettype wire

// ----- hdl/oate_ctrl.sv -----
// Controller state machine sequencing each request over the table memory.
`default_nettype none

module oate_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  oate_pkg::oate_sts_t sts_i,
  output oate_pkg::oate_ctl_t ctl_o,
  output logic                busy_o
);
  import oate_pkg::*;

  oate_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    busy_o  = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.req_load = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.command)
          CMD_INSERT: begin
            if (sts_i.pos_gt_count) begin
              ctl_o.res_en     = 1'b1;
              ctl_o.res_status = ST_BADPOS;
              state_d          = S_IDLE;
            end else if (sts_i.count_full) begin
              ctl_o.res_en     = 1'b1;
              ctl_o.res_status = ST_FULL;
              state_d          = S_IDLE;
            end else begin
              ctl_o.ptr_op = PTR_COUNT;
              state_d      = S_INS_CHK;
            end
          end
          CMD_DELETE: begin
            if (!sts_i.pos_lt_count) begin
              ctl_o.res_en     = 1'b1;
              ctl_o.res_status = ST_BADPOS;
              state_d          = S_IDLE;
            end else begin
              ctl_o.ptr_op = PTR_POS;
              state_d      = S_DEL_CHK;
            end
          end
          CMD_SEARCH: begin
            ctl_o.ptr_op = PTR_ZERO;
            state_d      = S_SRCH_CHK;
          end
          CMD_SORT: begin
            if (sts_i.count_lt2) begin
              ctl_o.res_en     = 1'b1;
              ctl_o.res_status = ST_OK;
              state_d          = S_IDLE;
            end else begin
              ctl_o.pass_op = PASS_LOAD;
              state_d       = S_SORT_PASS;
            end
          end
          CMD_DUMP: begin
            if (sts_i.count_zero) begin
              ctl_o.res_en     = 1'b1;
              ctl_o.res_status = ST_EMPTY;
              state_d          = S_IDLE;
            end else begin
              ctl_o.ptr_op = PTR_ZERO;
              state_d      = S_DUMP_RD;
            end
          end
          default: begin
            ctl_o.res_en     = 1'b1;
            ctl_o.res_status = ST_BADPOS;
            state_d          = S_IDLE;
          end
        endcase
      end
      S_INS_CHK: begin
        if (sts_i.ptr_gt_pos) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = RA_PTR_M1;
          state_d      = S_INS_WR;
        end else begin
          ctl_o.wr_en      = 1'b1;
          ctl_o.wa_sel     = WA_PTR;
          ctl_o.wd_sel     = WD_OPERAND;
          ctl_o.cnt_op     = CNT_INC;
          ctl_o.res_en     = 1'b1;
          ctl_o.res_status = ST_OK;
          state_d          = S_IDLE;
        end
      end
      S_INS_WR: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wa_sel = WA_PTR;
        ctl_o.wd_sel = WD_RDATA;
        ctl_o.ptr_op = PTR_DEC;
        state_d      = S_INS_CHK;
      end
      S_DEL_CHK: begin
        if (sts_i.ptr_next_lt_count) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = RA_PTR_P1;
          state_d      = S_DEL_WR;
        end else begin
          ctl_o.cnt_op     = CNT_DEC;
          ctl_o.res_en     = 1'b1;
          ctl_o.res_status = ST_OK;
          state_d          = S_IDLE;
        end
      end
      S_DEL_WR: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wa_sel = WA_PTR;
        ctl_o.wd_sel = WD_RDATA;
        ctl_o.ptr_op = PTR_INC;
        state_d      = S_DEL_CHK;
      end
      S_SRCH_CHK: begin
        if (sts_i.ptr_lt_count) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = RA_PTR;
          state_d      = S_SRCH_CMP;
        end else begin
          ctl_o.res_en     = 1'b1;
          ctl_o.res_status = ST_NOTFOUND;
          state_d          = S_IDLE;
        end
      end
      S_SRCH_CMP: begin
        if (sts_i.match) begin
          ctl_o.res_en     = 1'b1;
          ctl_o.res_status = ST_OK;
          ctl_o.res_kind   = RES_INDEX;
          state_d          = S_IDLE;
        end else begin
          ctl_o.ptr_op = PTR_INC;
          state_d      = S_SRCH_CHK;
        end
      end
      S_SORT_PASS: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = RA_ZERO;
        ctl_o.ptr_op = PTR_ONE;
        state_d      = S_SORT_LD;
      end
      S_SORT_LD: begin
        ctl_o.carry_op = CARRY_RDATA;
        state_d        = S_SORT_CHK;
      end
      S_SORT_CHK: begin
        if (sts_i.ptr_lt_count) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = RA_PTR;
          state_d      = S_SORT_WR;
        end else begin
          ctl_o.wr_en   = 1'b1;
          ctl_o.wa_sel  = WA_PTR_M1;
          ctl_o.wd_sel  = WD_CARRY;
          ctl_o.pass_op = PASS_DEC;
          if (sts_i.pass_last) begin
            ctl_o.res_en     = 1'b1;
            ctl_o.res_status = ST_OK;
            state_d          = S_IDLE;
          end else begin
            state_d = S_SORT_PASS;
          end
        end
      end
      S_SORT_WR: begin
        ctl_o.wr_en    = 1'b1;
        ctl_o.wa_sel   = WA_PTR_M1;
        ctl_o.wd_sel   = WD_MIN;
        ctl_o.carry_op = CARRY_MAX;
        ctl_o.ptr_op   = PTR_INC;
        state_d        = S_SORT_CHK;
      end
      S_DUMP_RD: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = RA_PTR;
        state_d      = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        ctl_o.res_en     = 1'b1;
        ctl_o.res_status = ST_OK;
        ctl_o.res_kind   = RES_DUMP;
        if (sts_i.ptr_next_lt_count) begin
          ctl_o.ptr_op = PTR_INC;
          state_d      = S_DUMP_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/oate_dp.sv -----
// Datapath: table memory, count, pointer, pass counter, sort carry and result register.
`default_nettype none

module oate_dp #(
  parameter int unsigned DEPTH = oate_pkg::DepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  oate_pkg::oate_req_t req_i,
  input  oate_pkg::oate_ctl_t ctl_i,
  output oate_pkg::oate_sts_t sts_o,
  output logic                res_valid_o,
  output oate_pkg::oate_res_t res_o
);
  import oate_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned ExtW = CntW + IdxOutW;

  oate_req_t               req_q;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         ptr_q, ptr_d;
  logic [CntW-1:0]         pass_q, pass_d;
  logic signed [DataW-1:0] carry_q, carry_d;
  logic signed [DataW-1:0] rd_q;
  logic signed [DataW-1:0] mem [DEPTH];
  oate_res_t               res_q, res_d;
  logic                    res_valid_q;

  logic [CmpW-1:0]         pos_ext, cnt_ext, ptr_ext;
  logic [CntW:0]           ptr_inc;
  logic [CntW-1:0]         ptr_m1;
  logic [IdxW-1:0]         rd_addr, wr_addr;
  logic signed [DataW-1:0] wr_data, min_val, max_val;
  logic                    rd_lt;
  logic [ExtW-1:0]         idx_ext;

  assign pos_ext = CmpW'(req_q.position);
  assign cnt_ext = CmpW'(count_q);
  assign ptr_ext = CmpW'(ptr_q);
  assign ptr_inc = {1'b0, ptr_q} + 1'b1;
  assign ptr_m1  = ptr_q - 1'b1;
  assign idx_ext = ExtW'(ptr_q);

  assign rd_lt   = (rd_q < carry_q);
  assign min_val = rd_lt ? rd_q : carry_q;
  assign max_val = rd_lt ? carry_q : rd_q;

  always_comb begin
    sts_o.command           = req_q.command;
    sts_o.pos_gt_count      = (pos_ext > cnt_ext);
    sts_o.pos_lt_count      = (pos_ext < cnt_ext);
    sts_o.count_full        = (count_q == CntW'(DEPTH));
    sts_o.count_zero        = (count_q == '0);
    sts_o.count_lt2         = (count_q < CntW'(2));
    sts_o.ptr_gt_pos        = (ptr_ext > pos_ext);
    sts_o.ptr_lt_count      = (ptr_q < count_q);
    sts_o.ptr_next_lt_count = (ptr_inc < {1'b0, count_q});
    sts_o.match             = (rd_q == req_q.operand_value);
    sts_o.pass_last         = (pass_q == CntW'(1));
  end

  always_comb begin
    case (ctl_i.rd_sel)
      RA_PTR:    rd_addr = ptr_q[IdxW-1:0];
      RA_PTR_M1: rd_addr = ptr_m1[IdxW-1:0];
      RA_PTR_P1: rd_addr = ptr_inc[IdxW-1:0];
      default:   rd_addr = '0;
    endcase
    wr_addr = (ctl_i.wa_sel == WA_PTR_M1) ? ptr_m1[IdxW-1:0] : ptr_q[IdxW-1:0];
    case (ctl_i.wd_sel)
      WD_RDATA:   wr_data = rd_q;
      WD_OPERAND: wr_data = req_q.operand_value;
      WD_MIN:     wr_data = min_val;
      default:    wr_data = carry_q;
    endcase
  end

  always_comb begin
    case (ctl_i.ptr_op)
      PTR_ZERO:  ptr_d = '0;
      PTR_ONE:   ptr_d = CntW'(1);
      PTR_COUNT: ptr_d = count_q;
      PTR_POS:   ptr_d = pos_ext[CntW-1:0];
      PTR_INC:   ptr_d = ptr_inc[CntW-1:0];
      PTR_DEC:   ptr_d = ptr_m1;
      default:   ptr_d = ptr_q;
    endcase
    case (ctl_i.cnt_op)
      CNT_INC: count_d = count_q + 1'b1;
      CNT_DEC: count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
    case (ctl_i.pass_op)
      PASS_LOAD: pass_d = count_q - 1'b1;
      PASS_DEC:  pass_d = pass_q - 1'b1;
      default:   pass_d = pass_q;
    endcase
    case (ctl_i.carry_op)
      CARRY_RDATA: carry_d = rd_q;
      CARRY_MAX:   carry_d = max_val;
      default:     carry_d = carry_q;
    endcase
  end

  always_comb begin
    res_d.status      = ctl_i.res_status;
    res_d.found_index = '0;
    res_d.element     = '0;
    res_d.last        = 1'b1;
    case (ctl_i.res_kind)
      RES_INDEX: begin
        res_d.found_index = idx_ext[IdxOutW-1:0];
      end
      RES_DUMP: begin
        res_d.found_index = idx_ext[IdxOutW-1:0];
        res_d.element     = rd_q;
        res_d.last        = !sts_o.ptr_next_lt_count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      pass_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      pass_q      <= pass_d;
      res_valid_q <= ctl_i.res_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.req_load) begin
      req_q <= req_i;
    end
    if (ctl_i.res_en) begin
      res_q <= res_d;
    end
    carry_q <= carry_d;
  end

  // single-port style table: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- hdl/ordered_array_table_engine_unit.sv -----
// Top level of the ordered array table engine: controller, datapath and checks.
//
//   channel   direction  signals                 handshake
//   request   in         start, req_i            taken when start high and busy low
//   result    out        res_valid_o, res_o      one-cycle strobe, always taken
//
// Each element visited costs a registered read of the table and then a write
// or compare step, and the sort makes count - 1 bubble passes over the table.
// A dump issues one result per element, the final one marked by last.
// Reset clears the controller, count, pointer, pass counter and result strobe;
// the table itself is not cleared. busy stays high until the final result is
// issued; results cannot be held off, so nothing on the result side stalls.
`default_nettype none

module ordered_array_table_engine_unit #(
  parameter int unsigned DEPTH = oate_pkg::DepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  oate_pkg::oate_req_t req_i,
  output logic                busy,
  output logic                res_valid_o,
  output oate_pkg::oate_res_t res_o
);
  import oate_pkg::*;

  // command and status between the controller and the datapath
  oate_ctl_t ctl;
  oate_sts_t sts;

  // sequence each request: decode, walk the table, issue results
  oate_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy)
  );

  // hold the table, the count and the result register
  oate_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // a result is only ever issued by a request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result strobe without a request in flight");

  // an accepted request keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start work");

  // never grow a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts.count_full && (ctl.cnt_op == CNT_INC)))
    else $error("insert into a full table");

  // the final result of a request is never directly followed by another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !res_valid_o)
    else $error("result issued straight after a final result");

endmodule

`default_nettype wire

// ----- test/ordered_array_table_engine_unit_tb.sv -----
// Self-checking testbench for the ordered array table engine: directed table, then random requests.
module ordered_array_table_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oate_pkg::*;

  localparam int unsigned TableDepth     = DepthDefault;
  localparam int unsigned RandomRequests = 210;
  localparam int unsigned SegmentLength  = 25;
  // A full dump is the longest burst of results. Leave margin.
  localparam int unsigned SettleCycles   = 80;

  // Codes the block does not define; each must come back as a bad position.
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  // Random traffic runs in segments, each with its own mix of requests.
  localparam int unsigned MIX_GROW   = 0;
  localparam int unsigned MIX_SHRINK = 1;
  localparam int unsigned MIX_CHURN  = 2;

  localparam logic signed [DataW-1:0] MostNegative = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] MostPositive = 32'sh7fff_ffff;

  // One row of the directed table. Where fixed is set, the single result is
  // typed in as status; otherwise the row is checked against the table copy.
  typedef struct packed {
    logic [2:0]              command;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] operand_value;
    logic                    fixed;
    logic [2:0]              status;
  } directed_row_t;

  localparam int unsigned DirectedCount = 24;
  localparam directed_row_t DirectedRows [DirectedCount] = '{
    // empty table straight after reset
    '{CMD_DUMP,   6'd0,  32'sd0,       1'b1, ST_EMPTY},
    '{CMD_DELETE, 6'd0,  32'sd0,       1'b1, ST_BADPOS},
    '{CMD_SEARCH, 6'd0,  32'sd0,       1'b1, ST_NOTFOUND},
    '{CMD_SORT,   6'd0,  32'sd0,       1'b1, ST_OK},
    '{CMD_INSERT, 6'd1,  32'sd7,       1'b1, ST_BADPOS},
    '{CMD_INSERT, 6'd63, -32'sd1,      1'b1, ST_BADPOS},
    // undefined commands, all bits of the position and value set on the last
    '{CMD_RSVD_5, 6'd0,  32'sd0,       1'b1, ST_BADPOS},
    '{CMD_RSVD_6, 6'd5,  32'sd5,       1'b1, ST_BADPOS},
    '{CMD_RSVD_7, 6'd63, -32'sd1,      1'b1, ST_BADPOS},
    // fill with the extremes, at the front and at the end, then dump, search and sort
    '{CMD_INSERT, 6'd0,  MostPositive, 1'b1, ST_OK},
    '{CMD_INSERT, 6'd0,  MostNegative, 1'b1, ST_OK},
    '{CMD_INSERT, 6'd2,  32'sd0,       1'b1, ST_OK},
    '{CMD_INSERT, 6'd1,  -32'sd1,      1'b0, ST_OK},
    '{CMD_DUMP,   6'd0,  32'sd0,       1'b0, ST_OK},
    '{CMD_SEARCH, 6'd0,  MostNegative, 1'b0, ST_OK},
    '{CMD_SEARCH, 6'd0,  32'sd12345,   1'b1, ST_NOTFOUND},
    '{CMD_SORT,   6'd0,  32'sd0,       1'b1, ST_OK},
    '{CMD_DUMP,   6'd0,  32'sd0,       1'b0, ST_OK},
    '{CMD_SEARCH, 6'd0,  MostPositive, 1'b0, ST_OK},
    // delete at the count, at the last entry and at the front, then insert past the count and dump
    '{CMD_DELETE, 6'd4,  32'sd0,       1'b1, ST_BADPOS},
    '{CMD_DELETE, 6'd3,  32'sd0,       1'b0, ST_OK},
    '{CMD_DELETE, 6'd0,  32'sd0,       1'b0, ST_OK},
    '{CMD_INSERT, 6'd3,  32'sd9,       1'b1, ST_BADPOS},
    '{CMD_DUMP,   6'd0,  32'sd0,       1'b0, ST_OK}
  };

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  oate_req_t req_i  = '0;
  logic      busy;
  logic      res_valid_o;
  oate_res_t res_o;

  // Own copy of the table, advanced once per accepted request.
  logic signed [DataW-1:0] shadow_table [TableDepth];
  int unsigned             shadow_count = 0;

  // Results still owed by the block, oldest first.
  oate_res_t   awaited_results [$];
  oate_res_t   oldest_result;
  int unsigned failures = 0;

  always #5 clk_i = ~clk_i;

  ordered_array_table_engine_unit u_dut (
    .clk_i,
    .rst_ni,
    .start,
    .req_i,
    .busy,
    .res_valid_o,
    .res_o
  );

  // Single result that carries a status only.
  function automatic oate_res_t status_result(input logic [2:0] st);
    oate_res_t res;
    res.status      = st;
    res.found_index = '0;
    res.element     = '0;
    res.last        = 1'b1;
    return res;
  endfunction

  // Apply one request to the table copy and return the results it causes.
  task automatic table_apply(input oate_req_t r, output oate_res_t outcome [$]);
    int unsigned             pos;
    int unsigned             hit;
    int                      k;
    int                      j;
    logic signed [DataW-1:0] held;
    oate_res_t               res;
    pos     = r.position;
    outcome = {};
    case (r.command)
      CMD_INSERT: begin
        // A position past the count is refused before fullness is looked at.
        if (pos > shadow_count) begin
          outcome.push_back(status_result(ST_BADPOS));
        end else if (shadow_count == TableDepth) begin
          outcome.push_back(status_result(ST_FULL));
        end else begin
          for (k = shadow_count; k > pos; k--) shadow_table[k] = shadow_table[k-1];
          shadow_table[pos] = r.operand_value;
          shadow_count++;
          outcome.push_back(status_result(ST_OK));
        end
      end
      CMD_DELETE: begin
        if (pos >= shadow_count) begin
          outcome.push_back(status_result(ST_BADPOS));
        end else begin
          for (k = pos; k + 1 < shadow_count; k++) shadow_table[k] = shadow_table[k+1];
          shadow_count--;
          outcome.push_back(status_result(ST_OK));
        end
      end
      CMD_SEARCH: begin
        // Lowest matching index wins.
        hit = TableDepth;
        for (k = 0; k < shadow_count; k++) begin
          if (hit == TableDepth && shadow_table[k] == r.operand_value) hit = k;
        end
        if (hit == TableDepth) begin
          outcome.push_back(status_result(ST_NOTFOUND));
        end else begin
          res = status_result(ST_OK);
          res.found_index = IdxOutW'(hit);
          outcome.push_back(res);
        end
      end
      CMD_SORT: begin
        // Ascending signed order; equal entries keep their relative order.
        for (k = 1; k < shadow_count; k++) begin
          held = shadow_table[k];
          j    = k;
          while (j > 0 && shadow_table[j-1] > held) begin
            shadow_table[j] = shadow_table[j-1];
            j--;
          end
          shadow_table[j] = held;
        end
        outcome.push_back(status_result(ST_OK));
      end
      CMD_DUMP: begin
        if (shadow_count == 0) begin
          outcome.push_back(status_result(ST_EMPTY));
        end else begin
          for (k = 0; k < shadow_count; k++) begin
            res.status      = ST_OK;
            res.found_index = IdxOutW'(k);
            res.element     = shadow_table[k];
            res.last        = (k + 1 == shadow_count);
            outcome.push_back(res);
          end
        end
      end
      default: outcome.push_back(status_result(ST_BADPOS));
    endcase
  endtask

  // Present one request after an idle gap and hold it until it is taken.
  // With no gap, start stays high and only the payload moves on, so start
  // never gets two assignments in one step.
  task automatic issue_request(input oate_req_t r, input int unsigned gap,
                               input logic fixed, input logic [2:0] fixed_status);
    oate_res_t outcome [$];
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    // Taken at the first edge that sees busy low.
    do @(posedge clk_i); while (busy);
    table_apply(r, outcome);
    if (fixed) outcome = '{status_result(fixed_status)};
    foreach (outcome[k]) awaited_results.push_back(outcome[k]);
  endtask

  // Drop start and hold until every owed result has arrived. The request
  // just taken always owes at least one, so time advances before returning.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // Draw a request suited to the current mix, mostly well formed so that the
  // table fills up, empties and gets sorted; a little noise on top.
  function automatic oate_req_t random_request(input int unsigned mix);
    oate_req_t   r;
    int unsigned pick;
    int unsigned ins_w;
    int unsigned del_w;
    ins_w = (mix == MIX_GROW) ? 64 : (mix == MIX_SHRINK) ? 10 : 35;
    del_w = (mix == MIX_GROW) ? 10 : (mix == MIX_SHRINK) ? 64 : 30;
    pick  = $urandom_range(0, 99);
    r.command  = CMD_SEARCH;
    r.position = PosW'($urandom_range(0, 63));
    // Narrow values a third of the time so that duplicates and ties occur.
    if ($urandom_range(0, 2) == 0) r.operand_value = DataW'($urandom_range(0, 9)) - 32'sd5;
    else r.operand_value = $urandom();
    if (pick < 6) begin
      r.command = 3'($urandom_range(0, 7));
    end else if (pick < 6 + ins_w) begin
      r.command = CMD_INSERT;
      if ($urandom_range(0, 9) != 0 || shadow_count == 63) begin
        r.position = PosW'($urandom_range(0, shadow_count));
      end else begin
        r.position = PosW'($urandom_range(shadow_count + 1, 63));
      end
    end else if (pick < 6 + ins_w + del_w) begin
      r.command = CMD_DELETE;
      if (shadow_count > 0 && $urandom_range(0, 9) != 0) begin
        r.position = PosW'($urandom_range(0, shadow_count - 1));
      end else begin
        r.position = PosW'($urandom_range(shadow_count, 63));
      end
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        r.command = CMD_SEARCH;
        // Mostly look for a key that is held, to hit matches at any depth.
        if (shadow_count > 0 && pick < 4) begin
          r.operand_value = shadow_table[$urandom_range(0, shadow_count - 1)];
        end
      end else if (pick < 8) begin
        r.command = CMD_SORT;
      end else begin
        r.command = CMD_DUMP;
      end
    end
    return r;
  endfunction

  initial begin : stimulus
    oate_req_t   r;
    int unsigned mix;
    int unsigned gap;
    logic        burst;
    mix   = MIX_GROW;
    burst = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: walk the table row by row.
    foreach (DirectedRows[k]) begin
      r.command       = DirectedRows[k].command;
      r.position      = DirectedRows[k].position;
      r.operand_value = DirectedRows[k].operand_value;
      issue_request(r, $urandom_range(0, 9), DirectedRows[k].fixed, DirectedRows[k].status);
    end
    // Hold off the sender until the directed results are all in.
    drain_results();

    // Random part, in segments: the first one grows the table towards full,
    // later ones pick a mix at random. Some segments run with no idle gaps.
    for (int n = 0; n < RandomRequests; n++) begin
      if (n % SegmentLength == 0 && n > 0) begin
        mix   = $urandom_range(MIX_GROW, MIX_CHURN);
        burst = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 1) == 0) drain_results();
      end
      gap = burst ? 0 : $urandom_range(0, 9);
      issue_request(random_request(mix), gap, 1'b0, ST_OK);
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS ordered_array_table_engine_unit");
    end else begin
      $display("FAIL ordered_array_table_engine_unit");
    end
    $finish;
  end

  // Take every strobed result and compare it with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (awaited_results.size() == 0) begin
        $error("result with none owed: status %0d index %0d element %0d last %0d",
               res_o.status, res_o.found_index, res_o.element, res_o.last);
        failures++;
      end else begin
        oldest_result = awaited_results.pop_front();
        if (res_o.status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, res_o.status);
          failures++;
        end
        if (res_o.found_index !== oldest_result.found_index) begin
          $error("found_index: expected %0d, got %0d",
                 oldest_result.found_index, res_o.found_index);
          failures++;
        end
        if (res_o.element !== oldest_result.element) begin
          $error("element: expected %0d, got %0d", oldest_result.element, res_o.element);
          failures++;
        end
        if (res_o.last !== oldest_result.last) begin
          $error("last: expected %0d, got %0d", oldest_result.last, res_o.last);
          failures++;
        end
      end
    end
  end

  // Watchdog: a few times the slowest correct run, with a sort of a full
  // table on every request.
  initial begin : watchdog
    #15_000_000;
    $display("FAIL ordered_array_table_engine_unit");
    $finish;
  end

endmodule
